// ----- rtl/spectral_bin_threshold_hold_core_defines.svh -----
// ---------------------------------------------------------------------------
// spectral bin threshold hold: assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while rst is high
// ---------------------------------------------------------------------------
`ifndef SPECTRAL_BIN_THRESHOLD_HOLD_CORE_DEFINES_SVH
`define SPECTRAL_BIN_THRESHOLD_HOLD_CORE_DEFINES_SVH

// same-cycle implication
`define SBTH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBTH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sbth_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbth_pkg
// widths, reset values, codes and types of the spectral bin threshold hold
// ---------------------------------------------------------------------------
package sbth_pkg;

  localparam int unsigned FFT_SIZE_DEF = 1024;

  localparam int unsigned BIN_W   = 10;
  localparam int unsigned AMP_W   = 32;
  localparam int unsigned FREQ_W  = 32;
  localparam int unsigned THR_W   = 32;
  localparam int unsigned DAMP_W  = 16;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned CFG_W   = 16;

  localparam int unsigned HELD_W  = AMP_W + FREQ_W + CNT_W;
  localparam int unsigned PARAM_W = THR_W + DAMP_W;

  // result queue depth, covers the three pipeline stages plus slack
  localparam int unsigned OUT_DEPTH = 8;

  localparam logic [CNT_W-1:0]   HOLD_LEN_RST = 16'd20671;
  localparam logic [SCALE_W-1:0] SCALE_RST    = 16'd4096;
  localparam logic [THR_W-1:0]   BIN_THR_RST  = 32'd1677722;
  localparam logic [DAMP_W-1:0]  BIN_DAMP_RST = 16'd32440;
  localparam logic [AMP_W-1:0]   AMP_FLOOR    = 32'd17;

  typedef enum logic [1:0] {
    CFG_HOLD_LEN     = 2'd0,
    CFG_HOLD_FOREVER = 2'd1,
    CFG_THR_SCALE    = 2'd2,
    CFG_DAMP_SCALE   = 2'd3
  } sbth_cfg_t;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_WRITE  = 1'b1
  } sbth_action_t;

  typedef enum logic [0:0] {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } sbth_state_t;

  typedef struct packed {
    logic [BIN_W-1:0]         bin;
    logic [AMP_W-1:0]         amplitude;
    logic signed [FREQ_W-1:0] frequency;
    logic                     frame_end;
  } sbth_result_t;

endpackage

// ----- rtl/sbth_sample_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbth_sample_if
// input request channel: one spectral bin sample or one bin parameter write
// ---------------------------------------------------------------------------
interface sbth_sample_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [sbth_pkg::BIN_W-1:0]       bin;
  logic [sbth_pkg::AMP_W-1:0]       amplitude;
  logic signed [sbth_pkg::FREQ_W-1:0] frequency;
  logic [sbth_pkg::THR_W-1:0]       threshold;
  logic [sbth_pkg::DAMP_W-1:0]      damping;

  modport source (
    output valid, action, bin, amplitude, frequency, threshold, damping,
    input  ready
  );

  modport sink (
    input  valid, action, bin, amplitude, frequency, threshold, damping,
    output ready
  );
endinterface

// ----- rtl/sbth_result_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbth_result_if
// output request channel: held values of one processed bin
// ---------------------------------------------------------------------------
interface sbth_result_if;
  logic                               valid;
  logic                               ready;
  logic [sbth_pkg::BIN_W-1:0]         out_bin;
  logic [sbth_pkg::AMP_W-1:0]         out_amplitude;
  logic signed [sbth_pkg::FREQ_W-1:0] out_frequency;
  logic                               frame_end;

  modport source (
    output valid, out_bin, out_amplitude, out_frequency, frame_end,
    input  ready
  );

  modport sink (
    input  valid, out_bin, out_amplitude, out_frequency, frame_end,
    output ready
  );
endinterface

// ----- rtl/sbth_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbth_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module sbth_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/spectral_bin_threshold_hold_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spectral_bin_threshold_hold_core
// per-bin amplitude/frequency hold with change threshold, hold counter and
// damping; bin state and bin parameters live in two synchronous rams
// ---------------------------------------------------------------------------
//
//  channel  | kind            | moves
//  ---------+-----------------+---------------------------------------------
//  sample   | valid/ready in  | one bin sample (action 0) or bin write (1)
//  held     | valid/ready out | held values of one processed bin
//  cfg_*    | write only      | hold length, hold_forever, scales
//
//  one request per cycle sustained unless the interlock or the queue limit
//  stalls it; a sample result passes ram read, two multiply stages and
//  write-back into the queue; a request whose bin is still in the three
//  read-modify-write stages waits (interlock on the held-state ram)
//  after reset a clearing pass over all FFT_SIZE/2+1 bins (513 by default)
//  loads the reset values into both rams; requests wait, cfg writes are taken
//  requests stop once queued plus in-flight results reach the 8-entry queue
//
module spectral_bin_threshold_hold_core #(
  parameter int unsigned FFT_SIZE = sbth_pkg::FFT_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  sbth_sample_if.sink                 sample,
  sbth_result_if.source               held,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [sbth_pkg::CFG_W-1:0]  cfg_data
);

  localparam int unsigned NUM_BINS = FFT_SIZE / 2 + 1;
  localparam int unsigned TOP_BIN  = FFT_SIZE / 2;
  localparam int unsigned AW       = $clog2(NUM_BINS);
  localparam int unsigned PW       = $clog2(sbth_pkg::OUT_DEPTH);

  localparam int unsigned AMP_W  = sbth_pkg::AMP_W;
  localparam int unsigned FREQ_W = sbth_pkg::FREQ_W;
  localparam int unsigned CNT_W  = sbth_pkg::CNT_W;
  localparam int unsigned BIN_W  = sbth_pkg::BIN_W;

  // bin index widened for range test and ram addressing
  function automatic logic [AW-1:0] bin_addr(input logic [BIN_W-1:0] b);
    logic [31:0] w;
    w = {{(32-BIN_W){1'b0}}, b};
    return w[AW-1:0];
  endfunction

  function automatic logic bin_is_top(input logic [BIN_W-1:0] b);
    logic [31:0] w;
    w = {{(32-BIN_W){1'b0}}, b};
    return w == 32'(TOP_BIN);
  endfunction

  function automatic logic bin_in_range(input logic [BIN_W-1:0] b);
    logic [31:0] w;
    w = {{(32-BIN_W){1'b0}}, b};
    return w <= 32'(TOP_BIN);
  endfunction

  // configuration registers
  logic [CNT_W-1:0]             hold_len;
  logic                         hold_forever;
  logic [sbth_pkg::SCALE_W-1:0] threshold_scale;
  logic [sbth_pkg::SCALE_W-1:0] damping_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_len        <= sbth_pkg::HOLD_LEN_RST;
      hold_forever    <= 1'b0;
      threshold_scale <= sbth_pkg::SCALE_RST;
      damping_scale   <= sbth_pkg::SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sbth_pkg::CFG_HOLD_LEN:     hold_len        <= cfg_data;
        sbth_pkg::CFG_HOLD_FOREVER: hold_forever    <= cfg_data[0];
        sbth_pkg::CFG_THR_SCALE:    threshold_scale <= cfg_data;
        sbth_pkg::CFG_DAMP_SCALE:   damping_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing pass sequencer
  sbth_pkg::sbth_state_t state;
  sbth_pkg::sbth_state_t state_next;
  logic [AW-1:0]         clr_addr;
  logic                  clearing;

  always_comb begin
    state_next = state;
    case (state)
      sbth_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(NUM_BINS - 1)) state_next = sbth_pkg::ST_RUN;
      end
      sbth_pkg::ST_RUN: state_next = sbth_pkg::ST_RUN;
      default: state_next = sbth_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    case (state)
      sbth_pkg::ST_CLEAR: clearing = 1'b1;
      default:            clearing = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sbth_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_addr <= clr_addr + AW'(1);
    end
  end

  // pipeline valid and bin tags, used by the interlock
  logic             s1_valid, s2_valid, s3_valid;
  logic [BIN_W-1:0] s1_bin, s2_bin, s3_bin;

  // result queue
  sbth_pkg::sbth_result_t q_mem [sbth_pkg::OUT_DEPTH];
  logic [PW-1:0]          q_wr, q_rd;
  logic [PW:0]            q_count;
  logic [PW+1:0]          occupancy;
  logic                   q_push, q_pop;

  // request side
  logic hazard;
  logic accept;
  logic is_sample;
  logic is_write;
  logic capture_all;

  assign hazard = (s1_valid && s1_bin == sample.bin) ||
                  (s2_valid && s2_bin == sample.bin) ||
                  (s3_valid && s3_bin == sample.bin);

  // results in flight plus those queued must fit the queue
  assign occupancy = (PW+2)'(q_count) + (PW+2)'(s1_valid) + (PW+2)'(s2_valid)
                   + (PW+2)'(s3_valid);

  assign sample.ready = !clearing && !hazard &&
                        (occupancy < (PW+2)'(sbth_pkg::OUT_DEPTH));
  assign accept    = sample.valid && sample.ready;
  assign is_sample = accept && bin_in_range(sample.bin) &&
                     (sample.action == sbth_pkg::ACT_SAMPLE);
  assign is_write  = accept && bin_in_range(sample.bin) &&
                     (sample.action == sbth_pkg::ACT_WRITE);

  // first frame ends once the top bin sample has been taken
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_all <= 1'b1;
    end else if (is_sample && bin_is_top(sample.bin)) begin
      capture_all <= 1'b0;
    end
  end

  // held-state ram: {amplitude, frequency, counter}
  logic                        held_we;
  logic [AW-1:0]               held_waddr;
  logic [sbth_pkg::HELD_W-1:0] held_wdata;
  logic [sbth_pkg::HELD_W-1:0] held_rdata;

  // bin parameter ram: {threshold, damping}
  logic                         par_we;
  logic [AW-1:0]                par_waddr;
  logic [sbth_pkg::PARAM_W-1:0] par_wdata;
  logic [sbth_pkg::PARAM_W-1:0] par_rdata;

  sbth_ram #(
    .WIDTH (sbth_pkg::HELD_W),
    .DEPTH (NUM_BINS)
  ) u_held_ram (
    .clk   (clk),
    .we    (held_we),
    .waddr (held_waddr),
    .wdata (held_wdata),
    .raddr (bin_addr(sample.bin)),
    .rdata (held_rdata)
  );

  sbth_ram #(
    .WIDTH (sbth_pkg::PARAM_W),
    .DEPTH (NUM_BINS)
  ) u_par_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (bin_addr(sample.bin)),
    .rdata (par_rdata)
  );

  // bin writes go straight into the parameter ram; a later sample of the
  // same bin issues its read afterwards and sees the new values
  always_comb begin
    if (clearing) begin
      par_we    = 1'b1;
      par_waddr = clr_addr;
      par_wdata = {sbth_pkg::BIN_THR_RST, sbth_pkg::BIN_DAMP_RST};
    end else begin
      par_we    = is_write;
      par_waddr = bin_addr(sample.bin);
      par_wdata = {sample.threshold, sample.damping};
    end
  end

  // stage 1: ram data back, form |held - new|, threshold limit, damping gain
  logic [AMP_W-1:0]         s1_amp;
  logic signed [FREQ_W-1:0] s1_freq;
  logic                     s1_ff;
  logic [AMP_W-1:0]         s1_h;
  logic [FREQ_W-1:0]        s1_hfreq;
  logic [CNT_W-1:0]         s1_cnt;
  logic [sbth_pkg::THR_W-1:0]  s1_thr;
  logic [sbth_pkg::DAMP_W-1:0] s1_damp;
  logic [AMP_W-1:0]         s1_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= is_sample;
    end
    s1_bin  <= sample.bin;
    s1_amp  <= sample.amplitude;
    s1_freq <= sample.frequency;
    s1_ff   <= capture_all;
  end

  assign s1_h     = held_rdata[sbth_pkg::HELD_W-1 -: AMP_W];
  assign s1_hfreq = held_rdata[CNT_W +: FREQ_W];
  assign s1_cnt   = held_rdata[CNT_W-1:0];
  assign s1_thr   = par_rdata[sbth_pkg::PARAM_W-1 -: sbth_pkg::THR_W];
  assign s1_damp  = par_rdata[sbth_pkg::DAMP_W-1:0];
  assign s1_diff  = (s1_h > s1_amp) ? (s1_h - s1_amp) : (s1_amp - s1_h);

  // stage 2: replace decision, held * (damping * damping_scale)
  logic [AMP_W-1:0]         s2_amp;
  logic signed [FREQ_W-1:0] s2_freq;
  logic                     s2_ff;
  logic [AMP_W-1:0]         s2_h;
  logic [FREQ_W-1:0]        s2_hfreq;
  logic [CNT_W-1:0]         s2_cnt;
  logic [AMP_W-1:0]         s2_diff;
  logic [47:0]              s2_lim;
  logic [31:0]              s2_gain;
  logic                     s2_replace;
  logic [63:0]              s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_bin   <= s1_bin;
    s2_amp   <= s1_amp;
    s2_freq  <= s1_freq;
    s2_ff    <= s1_ff;
    s2_h     <= s1_h;
    s2_hfreq <= s1_hfreq;
    s2_cnt   <= s1_cnt;
    s2_diff  <= s1_diff;
    s2_lim   <= 48'(s1_thr) * 48'(threshold_scale);
    s2_gain  <= 32'(s1_damp) * 32'(damping_scale);
  end

  // diff in Q36.12 against threshold * scale; first frame or an expired
  // counter also force a capture
  assign s2_replace = s2_ff || (s2_cnt == '0) ||
                      ({4'b0, s2_diff, 12'b0} > s2_lim);
  assign s2_prod    = 64'(s2_h) * 64'(s2_gain);

  // stage 3: shift, saturate, floor, write back and queue the result
  logic [AMP_W-1:0]         s3_amp;
  logic signed [FREQ_W-1:0] s3_freq;
  logic [FREQ_W-1:0]        s3_hfreq;
  logic [CNT_W-1:0]         s3_cnt;
  logic                     s3_replace;
  logic [63:0]              s3_prod;
  logic [36:0]              s3_shift;
  logic [AMP_W-1:0]         s3_sat;
  logic [AMP_W-1:0]         s3_damped;
  logic [AMP_W-1:0]         s3_new_amp;
  logic [FREQ_W-1:0]        s3_new_freq;
  logic [CNT_W-1:0]         s3_new_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_bin     <= s2_bin;
    s3_amp     <= s2_amp;
    s3_freq    <= s2_freq;
    s3_hfreq   <= s2_hfreq;
    s3_cnt     <= s2_cnt;
    s3_replace <= s2_replace;
    s3_prod    <= s2_prod;
  end

  assign s3_shift  = s3_prod[63:27];
  assign s3_sat    = (|s3_shift[36:32]) ? '1 : s3_shift[31:0];
  assign s3_damped = (s3_sat < sbth_pkg::AMP_FLOOR) ? '0 : s3_sat;

  always_comb begin
    if (s3_replace) begin
      s3_new_amp  = s3_amp;
      s3_new_freq = s3_freq;
      s3_new_cnt  = hold_len;
    end else begin
      s3_new_amp  = s3_damped;
      s3_new_freq = s3_hfreq;
      s3_new_cnt  = hold_forever ? s3_cnt : (s3_cnt - CNT_W'(1));
    end
  end

  always_comb begin
    if (clearing) begin
      held_we    = 1'b1;
      held_waddr = clr_addr;
      held_wdata = '0;
    end else begin
      held_we    = s3_valid;
      held_waddr = bin_addr(s3_bin);
      held_wdata = {s3_new_amp, s3_new_freq, s3_new_cnt};
    end
  end

  // result queue: never back-pressures the pipeline, occupancy gates requests
  assign q_push = s3_valid;
  assign q_pop  = held.valid && held.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (q_push) q_wr <= q_wr + PW'(1);
      if (q_pop)  q_rd <= q_rd + PW'(1);
      case ({q_push, q_pop})
        2'b10:   q_count <= q_count + (PW+1)'(1);
        2'b01:   q_count <= q_count - (PW+1)'(1);
        default: q_count <= q_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr] <= '{bin:       s3_bin,
                       amplitude: s3_new_amp,
                       frequency: $signed(s3_new_freq),
                       frame_end: bin_is_top(s3_bin)};
    end
  end

  assign held.valid         = (q_count != '0);
  assign held.out_bin       = q_mem[q_rd].bin;
  assign held.out_amplitude = q_mem[q_rd].amplitude;
  assign held.out_frequency = q_mem[q_rd].frequency;
  assign held.frame_end     = q_mem[q_rd].frame_end;

endmodule

// ----- rtl/sbth_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbth_checker
// port-level checks of the spectral bin threshold hold core, bound to it
// ---------------------------------------------------------------------------
`include "spectral_bin_threshold_hold_core_defines.svh"

module sbth_checker #(
  parameter int unsigned FFT_SIZE = sbth_pkg::FFT_SIZE_DEF
) (
  input logic           clk,
  input logic           rst,
  sbth_sample_if.sink   sample,
  sbth_result_if.source held
);

  localparam logic [31:0] TOP_BIN = 32'(FFT_SIZE / 2);

  logic [31:0] out_bin_w;
  assign out_bin_w = {{(32-sbth_pkg::BIN_W){1'b0}}, held.out_bin};

  // clearing pass keeps requests out right after reset
  `SBTH_ASSERT_NOW(a_clear_after_reset, $past(rst), !sample.ready && !held.valid, "request taken during clearing pass")

  // only in-range bins ever produce a result
  `SBTH_ASSERT_NOW(a_bin_in_range, held.valid, out_bin_w <= TOP_BIN, "result for out-of-range bin")

  // frame end marks exactly the top bin
  `SBTH_ASSERT_NOW(a_frame_end, held.valid, held.frame_end == (out_bin_w == TOP_BIN), "frame_end does not match top bin")

  // stalled result holds
  `SBTH_ASSERT_NEXT(a_result_hold, held.valid && !held.ready, held.valid && $stable(held.out_bin) && $stable(held.out_amplitude), "stalled result changed")

endmodule

bind spectral_bin_threshold_hold_core sbth_checker #(
  .FFT_SIZE (FFT_SIZE)
) u_sbth_checker (
  .clk    (clk),
  .rst    (rst),
  .sample (sample),
  .held   (held)
);
